FILE: rtl/udsm_pkg.sv
package udsm_pkg;

    localparam int PAT_COUNT  = 8;
    localparam int HIST_DEPTH = 12;
    localparam int WIN_DEPTH  = HIST_DEPTH + 1;
    localparam int ID_W       = $clog2(PAT_COUNT);
    localparam int CNT_W      = $clog2(WIN_DEPTH);

    typedef logic [7:0] char_t;

    localparam char_t CH_PCT   = 8'h25;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_SPACE = 8'h20;

    // Signature text, right aligned: byte k holds the k-th character back from the end
    localparam logic [8*WIN_DEPTH-1:0] PAT_TEXT [PAT_COUNT] = '{
        (8*WIN_DEPTH)'("union select"),
        (8*WIN_DEPTH)'("drop table"),
        (8*WIN_DEPTH)'("select * from"),
        (8*WIN_DEPTH)'("' or '1'='1"),
        (8*WIN_DEPTH)'("' or 1=1"),
        (8*WIN_DEPTH)'("/etc/passwd"),
        (8*WIN_DEPTH)'("/bin/sh"),
        (8*WIN_DEPTH)'("cmd.exe")
    };

    localparam logic [CNT_W-1:0] PAT_LEN [PAT_COUNT] = '{
        4'd12, 4'd10, 4'd13, 4'd11, 4'd8, 4'd11, 4'd7, 4'd7
    };

    typedef struct packed {
        char_t payload_byte;
        logic  last_byte;
    } in_item_t;

    typedef struct packed {
        logic            attack_found;
        logic [ID_W-1:0] signature_id;
    } out_item_t;

    // Decoder to matcher: one step of decoded output
    typedef struct packed {
        logic  step;
        logic  take;
        logic  dual;
        char_t chr;
        logic  last;
    } dec_t;

    // Hex digit value with a flag for a valid digit
    function automatic logic [4:0] hex_digit(input char_t c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic char_t escape_value(input char_t first, input char_t second);
        logic [4:0] hi;
        logic [4:0] lo;
        char_t      r;
        hi = hex_digit(first);
        lo = hex_digit(second);
        if (!hi[4]) begin
            r = 8'h00;
        end
        else if (!lo[4]) begin
            r = {4'h0, hi[3:0]};
        end
        else begin
            r = {hi[3:0], lo[3:0]};
        end
        return r;
    endfunction

endpackage

FILE: rtl/udsm_stream_if.sv
interface udsm_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/url_decoded_signature_matcher.sv
// URL-decoded signature matcher.
// Channels: payload (sink) takes one raw payload byte per item with a last_byte
// flag; result (source) gives one item per payload, on its last byte, with
// attack_found and the lowest matching signature_id (0 when none).
// Each byte is URL-decoded ('%xx' escapes, '+' to space), lowercased and
// compared against eight signatures over a 13-byte window.
// Throughput: one payload byte per cycle while no last byte waits for the
// result register. Result path: the accepting edge loads the input register,
// and the result register loads from it, once free, after the combinational
// decode and compare.
// Reset: clears escape state, history count, match flags and both valid
// registers; the block is ready out of reset.
// Stall: a waiting result does not block bytes that give no result; a last
// byte waits in the input register until the result register is free, and
// payload ready drops only then.
module url_decoded_signature_matcher (
    input  logic          clk,
    input  logic          rst_n,
    udsm_stream_if.sink   payload,
    udsm_stream_if.source result
);

    logic                in_vld_reg;
    udsm_pkg::in_item_t  in_item_reg;
    logic                out_vld_reg;
    udsm_pkg::out_item_t out_item_reg;
    logic                proc;
    udsm_pkg::dec_t      dec;
    udsm_pkg::out_item_t match_res;

    // Process the held item unless it needs a result slot that is full
    assign proc = in_vld_reg
                  && (!in_item_reg.last_byte || !out_vld_reg || result.ready);
    assign payload.ready = !in_vld_reg || proc;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (payload.ready)
        begin
            in_vld_reg <= payload.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (payload.ready && payload.valid)
        begin
            in_item_reg <= payload.data;
        end
    end

    udsm_decoder u_decoder (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proc),
        .item  (in_item_reg),
        .dec   (dec)
    );

    udsm_matcher u_matcher (
        .clk    (clk),
        .rst_n  (rst_n),
        .dec    (dec),
        .result (match_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (proc && in_item_reg.last_byte)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_item_reg.last_byte)
        begin
            out_item_reg <= match_res;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_item_reg;

    a_last_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_item_reg.last_byte |=> out_vld_reg)
        else $error("last item did not produce a result");

endmodule

FILE: rtl/udsm_decoder.sv
module udsm_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  udsm_pkg::in_item_t  item,
    output udsm_pkg::dec_t      dec
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    phase_t          phase_reg;
    phase_t          phase_next;
    udsm_pkg::char_t held_reg;
    udsm_pkg::char_t plain;

    // Map '+' to space, pass everything else
    assign plain = (item.payload_byte == udsm_pkg::CH_PLUS) ? udsm_pkg::CH_SPACE
                                                            : item.payload_byte;

    // Decode the current item against the escape phase
    always_comb
    begin
        phase_next = phase_reg;
        dec.step   = step;
        dec.last   = item.last_byte;
        dec.take   = 1'b0;
        dec.dual   = 1'b0;
        dec.chr    = plain;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (item.last_byte)
                begin
                    // escape cut short: literal '%' then this byte
                    dec.take   = 1'b1;
                    dec.dual   = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                dec.take   = 1'b1;
                dec.chr    = udsm_pkg::escape_value(held_reg, item.payload_byte);
                phase_next = PH_IDLE;
            end
            default:
            begin
                if (item.payload_byte == udsm_pkg::CH_PCT && !item.last_byte)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    dec.take   = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    // Advance phase on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
        end
    end

    // Hold first digit after '%'
    always_ff @(posedge clk)
    begin
        if (step && phase_reg == PH_PCT)
        begin
            held_reg <= item.payload_byte;
        end
    end

    a_digit_after_pct: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == PH_DIGIT) |-> $past(phase_reg) == PH_PCT)
        else $error("digit phase entered without a pending escape");

endmodule

FILE: rtl/udsm_matcher.sv
module udsm_matcher (
    input  logic                clk,
    input  logic                rst_n,
    input  udsm_pkg::dec_t      dec,
    output udsm_pkg::out_item_t result
);

    localparam int PC = udsm_pkg::PAT_COUNT;
    localparam int HD = udsm_pkg::HIST_DEPTH;
    localparam int WD = udsm_pkg::WIN_DEPTH;
    localparam int CW = udsm_pkg::CNT_W;

    udsm_pkg::char_t hist_reg [HD];
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [PC-1:0]   flags_reg;
    logic [PC-1:0]   flags_all;
    logic [PC-1:0]   hits;
    logic [CW-1:0]   cnt_eff;
    udsm_pkg::char_t lc;
    udsm_pkg::char_t win [WD];

    // Lowercase A-Z
    assign lc = (dec.chr >= 8'h41 && dec.chr <= 8'h5A) ? (dec.chr + 8'h20) : dec.chr;

    // Build the window. A cut-short escape inserts '%' ahead of the byte; '%' never
    // ends a signature, so only the byte after it can complete a match.
    always_comb
    begin
        win[0] = lc;
        win[1] = dec.dual ? udsm_pkg::CH_PCT : hist_reg[0];
        for (int k = 2; k < WD; k++)
        begin
            win[k] = dec.dual ? hist_reg[k-2] : hist_reg[k-1];
        end
        if (dec.dual && cnt_reg != CW'(HD))
        begin
            cnt_eff = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_eff = cnt_reg;
        end
    end

    // Compare all signatures in parallel
    always_comb
    begin
        for (int p = 0; p < PC; p++)
        begin
            hits[p] = dec.step && dec.take
                      && (cnt_eff >= udsm_pkg::PAT_LEN[p] - 1'b1);
            for (int k = 0; k < WD; k++)
            begin
                if (CW'(k) < udsm_pkg::PAT_LEN[p]
                    && win[k] != udsm_pkg::PAT_TEXT[p][8*k +: 8])
                begin
                    hits[p] = 1'b0;
                end
            end
        end
    end

    assign flags_all = flags_reg | hits;

    // Pick the lowest matched signature
    always_comb
    begin
        result.attack_found = |flags_all;
        result.signature_id = '0;
        for (int p = PC - 1; p >= 0; p--)
        begin
            if (flags_all[p])
            begin
                result.signature_id = udsm_pkg::ID_W'(p);
            end
        end
    end

    assign cnt_next = (cnt_reg == CW'(HD)) ? cnt_reg : cnt_reg + 1'b1;

    // Track fill count and match flags; clear at end of payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flags_reg <= '0;
        end
        else if (dec.step)
        begin
            if (dec.last)
            begin
                cnt_reg   <= '0;
                flags_reg <= '0;
            end
            else
            begin
                flags_reg <= flags_all;
                if (dec.take)
                begin
                    cnt_reg <= cnt_next;
                end
            end
        end
    end

    // Shift decoded bytes into history
    always_ff @(posedge clk)
    begin
        if (dec.step && dec.take && !dec.last)
        begin
            hist_reg[0] <= lc;
            for (int k = 1; k < HD; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(HD))
        else $error("history count above depth");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        dec.step && dec.last |=> cnt_reg == '0 && flags_reg == '0)
        else $error("state not cleared after last item");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !result.attack_found |-> result.signature_id == '0)
        else $error("signature id set without a match");

endmodule
